[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the flood relay duplicate filter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/frdf_pkg.sv]
// Package for the flood relay duplicate filter: transfer types, status codes,
// register indexes, sequencer states and fixed constants. No dependencies.
package frdf_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int HEADER_BYTES      = 7;

    localparam logic [7:0] BCAST_ADDR = 8'hFF;
    localparam logic [3:0] TYPE_MASK  = 4'hF;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd1;
    localparam logic [2:0] STAT_SHORT     = 3'd2;
    localparam logic [2:0] STAT_ECHO      = 3'd3;
    localparam logic [2:0] STAT_MALFORMED = 3'd4;
    localparam logic [2:0] STAT_DUPLICATE = 3'd5;

    // item kinds
    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_NODE_ID     = 2'd0;
    localparam logic [1:0] REG_DEFAULT_TTL = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0] NODE_ID_RST     = 8'd1;
    localparam logic [7:0] DEFAULT_TTL_RST = 8'd3;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd248;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_RESULT
    } frdf_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  ttl;
        logic [15:0] seq;
        logic [7:0]  flags;
        logic [3:0]  msg_type;
        logic [7:0]  len;
        logic [7:0]  rx_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        deliver;
        logic        forward;
        logic [7:0]  out_src;
        logic [7:0]  out_dst;
        logic [7:0]  out_ttl;
        logic [15:0] out_seq;
        logic [3:0]  out_type;
        logic [7:0]  out_len;
    } rsp_t;

endpackage

[sv/flood_relay_duplicate_filter_core.sv]
// Flood relay duplicate filter: send stamping, receive checks, history scan.
// Depends on frdf_pkg, frdf_ram and assert_macros.svh.
//
// A local send, or a received header that fails the short, echo or length
// checks, goes from its transfer to the result state and from there into the
// output register, as the sequencer returns to idle for the next transfer. A
// received header that passes those checks is looked up in the (source,
// sequence) history by a single compare unit that reads one entry per cycle
// through the history RAM's read port; it goes through the scan, last and
// result states before its result is loaded into the output register. One
// item is in work at a time; req_ready is high while the sequencer is idle,
// also while an earlier result still waits in the output register, and a
// result that cannot be loaded holds the sequencer until rsp_ready frees the
// slot. History entries never written compare as source 0, sequence 0.
`include "assert_macros.svh"

module flood_relay_duplicate_filter_core #(
    parameter int HISTORY_DEPTH = frdf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  frdf_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output frdf_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frdf_pkg::PADDR_W-1:0]  paddr,
    input  logic [frdf_pkg::PDATA_W-1:0]  pwdata,
    output logic [frdf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import frdf_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
    localparam logic [8:0]    HDR9     = 9'(HEADER_BYTES);
    localparam int            ENTRY_W  = 24;

    // configuration
    logic [7:0] node_id_reg, default_ttl_reg, max_payload_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    // sequencer and datapath state
    frdf_state_t        state_reg, state_next;
    req_t               req_reg;
    logic [2:0]         status_reg, status_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               cmp_pend_reg, cmp_pend_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [15:0]        seq_reg, seq_next;
    logic [HISTORY_DEPTH-1:0] valid_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               req_xfer, slot_free, match, rec_en;
    logic [2:0]         pre_status, final_status;
    logic [ENTRY_W-1:0] key, rd_data, wr_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= NODE_ID_RST;
            default_ttl_reg <= DEFAULT_TTL_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_NODE_ID:     node_id_reg     <= pwdata[7:0];
                REG_DEFAULT_TTL: default_ttl_reg <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_NODE_ID:     prdata = {24'd0, node_id_reg};
            REG_DEFAULT_TTL: prdata = {24'd0, default_ttl_reg};
            REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // checks that need no history, taken straight off the incoming transfer
    always_comb
    begin
        if (req.kind == KIND_SEND)
        begin
            pre_status = (req.len > max_payload_reg) ? STAT_TOO_LONG : STAT_OK;
        end
        else if ({1'b0, req.rx_bytes} < HDR9)
        begin
            pre_status = STAT_SHORT;
        end
        else if (req.src == node_id_reg)
        begin
            pre_status = STAT_ECHO;
        end
        else if (({1'b0, req.len} + HDR9) > {1'b0, req.rx_bytes})
        begin
            pre_status = STAT_MALFORMED;
        end
        else
        begin
            pre_status = STAT_OK;
        end
    end

    // shared compare unit: one history entry per cycle
    assign key   = {req_reg.src, req_reg.seq};
    assign match = cmp_pend_reg && (cmp_vld_reg ? (rd_data == key) : (key == '0));

    assign final_status = hit_reg ? STAT_DUPLICATE : status_reg;
    assign rec_en  = (state_reg == S_RESULT) && slot_free && (final_status == STAT_OK);
    assign wr_data = (req_reg.kind == KIND_SEND) ? {node_id_reg, seq_reg}
                                                 : {req_reg.src, req_reg.seq};

    frdf_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (AW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (rec_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        cnt_next       = cnt_reg;
        cmp_pend_next  = cmp_pend_reg;
        cmp_vld_next   = cmp_vld_reg;
        hit_next       = hit_reg;
        wr_ptr_next    = wr_ptr_reg;
        seq_next       = seq_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    status_next   = pre_status;
                    cnt_next      = '0;
                    cmp_pend_next = 1'b0;
                    hit_next      = 1'b0;
                    if (req.kind == KIND_RECV && pre_status == STAT_OK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                hit_next      = hit_reg || match;
                cmp_pend_next = 1'b1;
                cmp_vld_next  = valid_reg[cnt_reg];
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                hit_next      = hit_reg || match;
                cmp_pend_next = 1'b0;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    rsp_next        = '0;
                    rsp_next.status = final_status;
                    if (final_status == STAT_OK)
                    begin
                        rsp_next.out_dst = req_reg.dst;
                        rsp_next.out_len = req_reg.len;
                        if (req_reg.kind == KIND_SEND)
                        begin
                            rsp_next.forward  = 1'b1;
                            rsp_next.out_src  = node_id_reg;
                            rsp_next.out_ttl  = default_ttl_reg;
                            rsp_next.out_seq  = seq_reg;
                            rsp_next.out_type = req_reg.msg_type & TYPE_MASK;
                            seq_next          = seq_reg + 16'd1;
                        end
                        else
                        begin
                            rsp_next.deliver  = (req_reg.dst == node_id_reg) ||
                                                (req_reg.dst == BCAST_ADDR);
                            rsp_next.forward  = (req_reg.ttl != 8'd0);
                            rsp_next.out_src  = req_reg.src;
                            rsp_next.out_ttl  = (req_reg.ttl != 8'd0) ?
                                                (req_reg.ttl - 8'd1) : 8'd0;
                            rsp_next.out_seq  = req_reg.seq;
                            rsp_next.out_type = req_reg.flags[5:2] & TYPE_MASK;
                        end
                        wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= STAT_OK;
            cnt_reg       <= '0;
            cmp_pend_reg  <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            seq_reg       <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            cnt_reg       <= cnt_next;
            cmp_pend_reg  <= cmp_pend_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            wr_ptr_reg    <= wr_ptr_next;
            seq_reg       <= seq_next;
            rsp_valid_reg <= rsp_valid_next;
            if (rec_en)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `ASSERT_IMPLIES(a_rsp_from_result, rsp_valid_reg && !$past(rsp_valid_reg), $past(state_reg == S_RESULT), "result appeared outside the result state")
    `ASSERT_IMPLIES(a_drop_is_quiet, rsp_valid_reg && rsp_reg.status != STAT_OK, !rsp_reg.deliver && !rsp_reg.forward && rsp_reg.out_seq == 16'd0, "dropped item carries header fields")
    `ASSERT_IMPLIES(a_scan_only_clean_recv, state_reg == S_SCAN, req_reg.kind == KIND_RECV && status_reg == STAT_OK, "history scan for a send or a dropped header")

endmodule

[sv/frdf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frdf_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
